// ===== sv/ert_pkg.sv =====
// Package: shared types, codes and constants for the engine RPM tracker.
`timescale 1ns / 1ps

package ert_pkg;

  localparam int unsigned RPM_W    = 16;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned SEC_W    = 32;
  localparam int unsigned TICK_W   = 10;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Dividend of the speed conversion: microseconds per minute.
  localparam int unsigned QUO_W = 26;
  localparam logic [QUO_W-1:0] US_PER_MINUTE = QUO_W'(60000000);
  localparam int unsigned CNT_W = 5;

  localparam logic [TICK_W-1:0] TICKS_PER_SECOND = TICK_W'(1000);

  localparam logic [RPM_W-1:0] STALL_LIM_RST    = RPM_W'(100);
  localparam logic [RPM_W-1:0] CRANKING_RPM_RST = RPM_W'(400);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STALL_LIM    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CRANKING_RPM = 1'b1;

  // Action codes
  localparam logic [1:0] ACT_PERIOD = 2'd0;
  localparam logic [1:0] ACT_EVAL   = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // Engine class codes
  localparam logic [1:0] CLASS_STALLED  = 2'd0;
  localparam logic [1:0] CLASS_CRANKING = 2'd1;
  localparam logic [1:0] CLASS_RUNNING  = 2'd2;

  typedef struct packed {
    logic [1:0]          action;
    logic [PERIOD_W-1:0] period_us;
    logic                trigger_seen;
  } ert_in_t;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic [1:0]       engine_state;
    logic             is_running_now;
    logic [SEC_W-1:0] running_seconds;
  } ert_out_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_CLASS = 4'b0100,
    S_PUSH  = 4'b1000
  } ert_state_e;

endpackage

// ===== sv/engine_rpm_state_tracker.sv =====
// Engine speed tracker: period to RPM conversion, engine class and run time.
`timescale 1ns / 1ps

// Sequence: an armed evaluate with triggers and a nonzero period runs a restoring
// divider, one quotient bit per cycle over 26 bits, then classifies and pushes;
// an armed zero period goes straight to classify, every other beat to the push step.
// A new beat is taken only once the previous one is pushed and the block is idle;
// a held output slot stalls the push step.
// Reset (rst_ni low, asynchronous): state cleared, stall limit 100, cranking_rpm 400.
module engine_rpm_state_tracker
  import ert_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ert_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ert_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // Configuration
  logic [RPM_W-1:0] stall_lim_q, cranking_rpm_q;

  // Architectural state
  logic [RPM_W-1:0]  speed_q, speed_d;
  logic [1:0]        class_q, class_d;
  logic              pending_q, pending_d;
  logic [SEC_W-1:0]  run_sec_q, run_sec_d;
  logic [TICK_W-1:0] tick_acc_q, tick_acc_d;
  logic              run_now_q, run_now_d;

  // Sequencer and divider
  ert_state_e          state_q, state_d;
  logic [PERIOD_W-1:0] div_q, div_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]    quo_q, quo_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  // Output register
  logic     out_valid_q, out_valid_d;
  ert_out_t out_q, out_d;

  // Divider step, tick and handshake signals
  logic [PERIOD_W:0]   rem_sh;
  logic [PERIOD_W:0]   rem_diff;
  logic                rem_ge;
  logic [TICK_W-1:0]   tick_inc;
  logic                in_fire;
  logic                slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // One restoring step: bring down the next dividend bit, trial subtract.
  assign rem_sh   = {rem_q, US_PER_MINUTE[cnt_q]};
  assign rem_diff = rem_sh - {1'b0, div_q};
  assign rem_ge   = (rem_sh >= {1'b0, div_q});

  assign tick_inc = tick_acc_q + TICK_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_lim_q    <= STALL_LIM_RST;
      cranking_rpm_q <= CRANKING_RPM_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_STALL_LIM:    stall_lim_q    <= cfg_data_i;
        REG_CRANKING_RPM: cranking_rpm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    speed_d     = speed_q;
    class_d     = class_q;
    pending_d   = pending_q;
    run_sec_d   = run_sec_q;
    tick_acc_d  = tick_acc_q;
    run_now_d   = run_now_q;
    div_d       = div_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          run_now_d = 1'b0;
          state_d   = S_PUSH;
          case (in_data_i.action)
            ACT_PERIOD: begin
              pending_d = 1'b1;
            end
            ACT_EVAL: begin
              if (!in_data_i.trigger_seen) begin
                // No triggers: engine has stopped.
                speed_d = '0;
                class_d = CLASS_STALLED;
              end else if (pending_q) begin
                pending_d = 1'b0;
                if (in_data_i.period_us == '0) begin
                  // Zero period reads as a quotient above every threshold.
                  quo_d   = '1;
                  state_d = S_CLASS;
                end else begin
                  div_d   = in_data_i.period_us;
                  rem_d   = '0;
                  quo_d   = '0;
                  cnt_d   = CNT_W'(QUO_W - 1);
                  state_d = S_DIV;
                end
              end
            end
            ACT_TICK: begin
              tick_acc_d = tick_inc;
              if (tick_inc >= TICKS_PER_SECOND) begin
                tick_acc_d = tick_inc - TICKS_PER_SECOND;
                run_sec_d  = (class_q == CLASS_RUNNING) ? run_sec_q + SEC_W'(1) : '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        rem_d = rem_ge ? rem_diff[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], rem_ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        // Apply the tests in order: stalled, cranking, running.
        if (quo_q < QUO_W'(stall_lim_q)) begin
          class_d = CLASS_STALLED;
          speed_d = '0;
        end else begin
          speed_d = (quo_q > QUO_W'({RPM_W{1'b1}})) ? '1 : quo_q[RPM_W-1:0];
          if (quo_q <= QUO_W'(cranking_rpm_q)) begin
            class_d = CLASS_CRANKING;
          end else begin
            class_d   = CLASS_RUNNING;
            run_now_d = 1'b1;
          end
        end
        state_d = S_PUSH;
      end
      S_PUSH: begin
        // Hold until the output slot frees, then load the snapshot.
        if (slot_free) begin
          out_valid_d           = 1'b1;
          out_d.rpm             = speed_q;
          out_d.engine_state    = class_q;
          out_d.is_running_now  = run_now_q;
          out_d.running_seconds = run_sec_q;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      speed_q     <= '0;
      class_q     <= CLASS_STALLED;
      pending_q   <= 1'b0;
      run_sec_q   <= '0;
      tick_acc_q  <= '0;
      run_now_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      speed_q     <= speed_d;
      class_q     <= class_d;
      pending_q   <= pending_d;
      run_sec_q   <= run_sec_d;
      tick_acc_q  <= tick_acc_d;
      run_now_q   <= run_now_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

`ifndef ASSERT_OFF
  a_rise_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_PUSH))
    else $error("output valid rose without a push step");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_q != '0))
    else $error("divider running with zero divisor");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < div_q))
    else $error("partial remainder not below divisor");

  a_running_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_running_now) |-> (out_q.engine_state == CLASS_RUNNING))
    else $error("running flag without running class");

  a_stalled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.engine_state == CLASS_STALLED)) |-> (out_q.rpm == '0))
    else $error("stalled engine with nonzero rpm");
`endif

endmodule
